/* hdl/hpid_pkg.sv */
// shared constants, types and the arctangent table of the heading pid steering block
package hpid_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W        = 5;

  localparam int PI_Q13       = 25736;
  localparam int TWO_PI_Q13   = 51472;
  localparam int HALF_PI_Q16  = 102944;

  localparam int POS_W  = 32;
  localparam int DIFF_W = 33;
  localparam int CRD_W  = 36;
  localparam int ANG_W  = 20;
  localparam int HEAD_W = 18;
  localparam int STEER_W = 16;

  localparam int PROP_GAIN_RST  = 256;
  localparam int INT_GAIN_RST   = 0;
  localparam int DERIV_GAIN_RST = 0;
  localparam int MAX_TURN_RST   = 8579;

  typedef enum logic [1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INT_GAIN   = 2'd1,
    REG_DERIV_GAIN = 2'd2,
    REG_MAX_TURN   = 2'd3
  } reg_idx_e;

  // atan(2^-i) in Q16 radians
  function automatic logic [ANG_W-1:0] atan_q16(input logic [CNT_W-1:0] idx);
    logic [ANG_W-1:0] v;
    unique case (idx)
      5'd0:    v = 20'd51472;
      5'd1:    v = 20'd30386;
      5'd2:    v = 20'd16055;
      5'd3:    v = 20'd8150;
      5'd4:    v = 20'd4091;
      5'd5:    v = 20'd2047;
      5'd6:    v = 20'd1024;
      5'd7:    v = 20'd512;
      5'd8:    v = 20'd256;
      5'd9:    v = 20'd128;
      5'd10:   v = 20'd64;
      5'd11:   v = 20'd32;
      5'd12:   v = 20'd16;
      5'd13:   v = 20'd8;
      5'd14:   v = 20'd4;
      5'd15:   v = 20'd2;
      5'd16:   v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/heading_pid_steering.sv */
// heading pid steering controller top level
//
//  channel  direction  signals
//  input    in         in_valid_i, in_stall_o, op_i, car_x_i, car_y_i, car_heading_i,
//                      goal_x_i, goal_y_i
//  output   out        out_valid_o, out_stall_i, steer_o
//  config   in         cfg_we_i, cfg_idx_i, cfg_data_i
//
//  a control request is taken in the idle state, then passes through the cordic unit
//  for the bearing, a step for the heading error, the shared multiplier and a step
//  to round and clamp; a clear request zeroes the integral and gives no result
//  reset restores the register defaults and clears error, integral and sign flag
//  a finished result waits in the output register while out_stall_i is high
module heading_pid_steering (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  op_i,
  input  logic signed [hpid_pkg::POS_W-1:0]     car_x_i,
  input  logic signed [hpid_pkg::POS_W-1:0]     car_y_i,
  input  logic signed [hpid_pkg::HEAD_W-1:0]    car_heading_i,
  input  logic signed [hpid_pkg::POS_W-1:0]     goal_x_i,
  input  logic signed [hpid_pkg::POS_W-1:0]     goal_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [hpid_pkg::STEER_W-1:0]   steer_o,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_idx_i,
  input  logic [15:0]                           cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_BEAR = 5'b00010,
    ST_ERR  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic signed [15:0] prop_gain_q, int_gain_q, deriv_gain_q;
  logic [14:0]        max_turn_q;

  logic signed [15:0] prev_err_q, prev_err_d;
  logic signed [31:0] err_sum_q, err_sum_d;
  logic               was_neg_q, was_neg_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] steer_q, steer_d;

  logic signed [18:0] th_q, th_d;
  logic signed [15:0] e_q, e_d;
  logic signed [48:0] prod_q, prod_d;
  logic signed [49:0] acc_q, acc_d;

  logic signed [18:0] th_in, th_a;
  logic signed [hpid_pkg::DIFF_W-1:0] dx, dy;
  logic               accept, crd_done;
  logic signed [15:0] dir;
  logic signed [20:0] e_raw, e_adj;
  logic signed [15:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] neg_acc, lim, acc_c;
  logic signed [42:0] rnd;
  logic signed [32:0] sum_ext;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign dx = hpid_pkg::DIFF_W'(goal_x_i) - hpid_pkg::DIFF_W'(car_x_i);
  assign dy = hpid_pkg::DIFF_W'(goal_y_i) - hpid_pkg::DIFF_W'(car_y_i);

  hpid_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && !op_i),
    .dx_i    (dx),
    .dy_i    (dy),
    .done_o  (crd_done),
    .angle_o (dir)
  );

  // heading wrapped once into [-pi, pi]
  always_comb begin
    th_in = 19'(car_heading_i);
    th_a  = th_in;
    if (th_in < -hpid_pkg::PI_Q13) th_a = th_in + 19'(hpid_pkg::TWO_PI_Q13);
    if (th_a > hpid_pkg::PI_Q13)   th_a = th_a - 19'(hpid_pkg::TWO_PI_Q13);
  end

  // heading error, unwrapped when heading and bearing sit on opposite sides
  always_comb begin
    e_raw = 21'(th_q) - 21'(dir);
    e_adj = e_raw;
    if ((e_raw > hpid_pkg::PI_Q13 || e_raw < -hpid_pkg::PI_Q13) &&
        ((th_q > 0 && dir < 0) || (th_q < 0 && dir > 0))) begin
      if (th_q > 0) e_adj = e_raw - 21'(hpid_pkg::TWO_PI_Q13);
      else          e_adj = e_raw + 21'(hpid_pkg::TWO_PI_Q13);
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (cnt_q)
      2'd0: begin
        mul_a = prop_gain_q;
        mul_b = 33'(e_q);
      end
      2'd1: begin
        mul_a = int_gain_q;
        mul_b = 33'(err_sum_q);
      end
      default: begin
        mul_a = deriv_gain_q;
        mul_b = 33'(e_q) - 33'(prev_err_q);
      end
    endcase
  end

  // negate, clamp and round the pid sum
  always_comb begin
    neg_acc = -51'(acc_q);
    lim     = $signed({28'd0, max_turn_q, 8'd0});
    if (neg_acc > lim)       acc_c = lim;
    else if (neg_acc < -lim) acc_c = -lim;
    else                     acc_c = neg_acc;
    rnd = 43'((acc_c + 51'sd128) >>> 8);
    if (rnd > $signed({28'd0, max_turn_q}))       steer_d = 16'(max_turn_q);
    else if (rnd < -$signed({28'd0, max_turn_q})) steer_d = -16'(max_turn_q);
    else                                          steer_d = rnd[15:0];
  end

  assign sum_ext = 33'(err_sum_q) + 33'(e_q);

  always_comb begin
    state_d     = state_q;
    prev_err_d  = prev_err_q;
    err_sum_d   = err_sum_q;
    was_neg_d   = was_neg_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    th_d        = th_q;
    e_d         = e_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_i) begin
            err_sum_d = '0;
          end else begin
            th_d    = th_a;
            state_d = ST_BEAR;
          end
        end
      end
      ST_BEAR: begin
        if (crd_done) state_d = ST_ERR;
      end
      ST_ERR: begin
        if (e_adj > 32767)       e_d = 16'sh7FFF;
        else if (e_adj < -32768) e_d = 16'sh8000;
        else                     e_d = e_adj[15:0];
        // sign change clears the integral
        if ((e_d > 0 && was_neg_q) || (e_d < 0 && !was_neg_q)) begin
          err_sum_d = '0;
          was_neg_d = !was_neg_q;
        end
        acc_d   = '0;
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d = mul_a * mul_b;
        if (cnt_q != 2'd0) acc_d = acc_q + 50'(prod_q);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 2'd3) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          prev_err_d  = e_q;
          if (sum_ext > 33'sh0_7FFF_FFFF)       err_sum_d = 32'sh7FFF_FFFF;
          else if (sum_ext < -33'sh0_8000_0000) err_sum_d = 32'sh8000_0000;
          else                                  err_sum_d = sum_ext[31:0];
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_err_q   <= '0;
      err_sum_q    <= '0;
      was_neg_q    <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      prop_gain_q  <= 16'(hpid_pkg::PROP_GAIN_RST);
      int_gain_q   <= 16'(hpid_pkg::INT_GAIN_RST);
      deriv_gain_q <= 16'(hpid_pkg::DERIV_GAIN_RST);
      max_turn_q   <= 15'(hpid_pkg::MAX_TURN_RST);
    end else begin
      state_q     <= state_d;
      prev_err_q  <= prev_err_d;
      err_sum_q   <= err_sum_d;
      was_neg_q   <= was_neg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (hpid_pkg::reg_idx_e'(cfg_idx_i))
          hpid_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data_i;
          hpid_pkg::REG_INT_GAIN:   int_gain_q   <= cfg_data_i;
          hpid_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data_i;
          hpid_pkg::REG_MAX_TURN:   max_turn_q   <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    th_q   <= th_d;
    e_q    <= e_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) steer_q <= steer_d;
  end

  assign out_valid_o = out_valid_q;
  assign steer_o     = steer_q;

endmodule

/* hdl/hpid_cordic.sv */
// iterative cordic vectoring unit giving atan2 of a position difference in q3.13 radians
module hpid_cordic (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [hpid_pkg::DIFF_W-1:0]   dx_i,
  input  logic signed [hpid_pkg::DIFF_W-1:0]   dy_i,
  output logic                                 done_o,
  output logic signed [hpid_pkg::STEER_W-1:0]  angle_o
);

  typedef enum logic [1:0] {
    CS_IDLE = 2'b01,
    CS_RUN  = 2'b10
  } crd_state_e;

  crd_state_e state_q, state_d;
  logic [hpid_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic done_q, done_d;
  logic zero_q, zero_d;
  logic signed [hpid_pkg::CRD_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [hpid_pkg::ANG_W-1:0] z_q, z_d;

  logic signed [hpid_pkg::CRD_W-1:0] dx_ext, dy_ext, xs, ys;
  logic signed [hpid_pkg::ANG_W-1:0] at;
  logic signed [hpid_pkg::ANG_W-1:0] z_rnd;

  assign dx_ext = hpid_pkg::CRD_W'(dx_i);
  assign dy_ext = hpid_pkg::CRD_W'(dy_i);
  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign at     = $signed(hpid_pkg::atan_q16(cnt_q));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    zero_d  = zero_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    unique case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          zero_d  = (dx_i == '0) && (dy_i == '0);
          cnt_d   = '0;
          state_d = CS_RUN;
          // quadrant pre-rotation into the right half plane
          if (dx_i < 0) begin
            if (dy_i >= 0) begin
              x_d = dy_ext;
              y_d = -dx_ext;
              z_d = hpid_pkg::ANG_W'(hpid_pkg::HALF_PI_Q16);
            end else begin
              x_d = -dy_ext;
              y_d = dx_ext;
              z_d = -hpid_pkg::ANG_W'(hpid_pkg::HALF_PI_Q16);
            end
          end else begin
            x_d = dx_ext;
            y_d = dy_ext;
            z_d = '0;
          end
        end
      end
      CS_RUN: begin
        if (y_q > 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + at;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - at;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == hpid_pkg::CNT_W'(hpid_pkg::CORDIC_STEPS - 1)) begin
          done_d  = 1'b1;
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      zero_q  <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  // round half up to q3.13 and clamp to +-pi
  assign z_rnd = (z_q + hpid_pkg::ANG_W'(4)) >>> 3;

  always_comb begin
    if (zero_q) begin
      angle_o = '0;
    end else if (z_rnd > hpid_pkg::PI_Q13) begin
      angle_o = hpid_pkg::STEER_W'(hpid_pkg::PI_Q13);
    end else if (z_rnd < -hpid_pkg::PI_Q13) begin
      angle_o = -hpid_pkg::STEER_W'(hpid_pkg::PI_Q13);
    end else begin
      angle_o = z_rnd[hpid_pkg::STEER_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule
